// ===== src/sgtr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled glyph text renderer package
// Shared payload types, job type, register indexes and a helper function.
// ----------------------------------------------------------------------------
package sgtr_pkg;

    localparam int MAX_GLYPH_W = 8;
    localparam int ADDR_MAX_W  = 12;
    localparam int ROW_IDX_W   = 4;
    localparam int COL_IDX_W   = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ENABLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT  = 3'd5;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PRINT = 1'b1;

    localparam logic [3:0]  SCALE_MIN  = 4'd1;
    localparam logic [3:0]  SCALE_MAX  = 4'd8;
    localparam logic [15:0] LIMIT_INIT = 16'd256;

    typedef struct packed {
        logic       action;
        logic       first_of_text;
        logic [7:0] char_code;
        logic [3:0] glyph_row;
        logic [4:0] row_bits;
    } t_in;

    typedef struct packed {
        logic [15:0] rect_x;
        logic [15:0] rect_y;
        logic [3:0]  side;
        logic [7:0]  color;
        logic        last;
    } t_out;

    typedef struct packed {
        logic                   is_print;
        logic                   ok;
        logic [ADDR_MAX_W-1:0]  addr;
        logic [MAX_GLYPH_W-1:0] bits;
        logic [15:0]            left;
        logic [15:0]            top;
        logic [3:0]             side;
        logic [7:0]             color;
    } t_job;

    function automatic logic [3:0] f_eff_scale(input logic [3:0] scale);
        logic [3:0] sc;
        if (scale == 4'd0) begin
            sc = SCALE_MIN;
        end else if (scale > SCALE_MAX) begin
            sc = SCALE_MAX;
        end else begin
            sc = scale;
        end
        return sc;
    endfunction

endpackage
`default_nettype wire

// ===== src/sgtr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sgtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== src/sgtr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Renderer front end
// Holds the configuration and the text cursor, and turns each item into a job.
// ----------------------------------------------------------------------------
module sgtr_front import sgtr_pkg::*; #(
    parameter int CHAR_COUNT   = 256,
    parameter int GLYPH_HEIGHT = 12,
    parameter int GLYPH_WIDTH  = 5,
    parameter int SCREEN_WIDTH = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_job_valid,
    input  wire logic                  i_job_ready,
    output t_job                       o_job
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_WRAP = 2'd1;
    localparam logic [1:0] F_MUL  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]  r_state, n_state;
    t_in         r_item;
    logic [15:0] r_char_index, n_char_index;
    logic [15:0] r_line_length, n_line_length;
    logic [15:0] r_line_top, n_line_top;
    logic [15:0] r_prod;

    logic [7:0]  r_draw_color;
    logic [7:0]  r_origin_x;
    logic [7:0]  r_origin_y;
    logic [3:0]  r_scale;
    logic        r_wrap_enable;
    logic [15:0] r_line_limit;

    logic [3:0]  w_sc;
    logic [6:0]  w_step;
    logic [16:0] w_end;
    logic        w_wrap;
    logic        w_print;
    logic        w_code_ok;
    logic        w_row_ok;
    logic        w_accept;

    assign w_sc     = f_eff_scale(r_scale);
    assign w_step   = 7'((GLYPH_WIDTH + 1) * int'(w_sc));
    assign w_end    = {1'b0, r_line_length} + 17'(w_step);
    assign w_wrap   = r_wrap_enable &&
                      ((w_end > {1'b0, r_line_limit}) || (w_end > 17'(SCREEN_WIDTH)));
    assign w_print  = (r_item.action == ACT_PRINT);
    assign w_code_ok = ({1'b0, r_item.char_code} < 9'(CHAR_COUNT));
    assign w_row_ok  = ({1'b0, r_item.glyph_row} < 5'(GLYPH_HEIGHT));

    assign o_in_ready  = (r_state == F_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_job_valid = (r_state == F_PUSH);

    always_comb begin
        o_job.is_print = w_print;
        o_job.ok       = w_print ? w_code_ok : (w_code_ok && w_row_ok);
        o_job.addr     = ADDR_MAX_W'(int'(r_item.char_code) * GLYPH_HEIGHT +
                                     (w_print ? 0 : int'(r_item.glyph_row)));
        o_job.bits     = MAX_GLYPH_W'(r_item.row_bits);
        o_job.left     = {8'd0, r_origin_x} + r_prod;
        o_job.top      = r_line_top;
        o_job.side     = w_sc;
        o_job.color    = r_draw_color;
    end

    always_comb begin
        n_state       = r_state;
        n_char_index  = r_char_index;
        n_line_length = r_line_length;
        n_line_top    = r_line_top;
        case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.action == ACT_PRINT) begin
                        n_state = F_WRAP;
                        if (i_in_data.first_of_text) begin
                            n_char_index  = 16'd0;
                            n_line_length = {8'd0, r_origin_x};
                            n_line_top    = {8'd0, r_origin_y};
                        end
                    end else begin
                        n_state = F_PUSH;
                    end
                end
            end
            F_WRAP: begin
                n_state = F_MUL;
                if (w_wrap) begin
                    n_line_top    = r_line_top + 16'(GLYPH_HEIGHT * int'(w_sc));
                    n_char_index  = 16'd0;
                    n_line_length = {8'd0, r_origin_x};
                end
            end
            F_MUL: begin
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (i_job_ready) begin
                    n_state = F_IDLE;
                    if (w_print) begin
                        n_char_index  = r_char_index + 16'd1;
                        n_line_length = r_line_length + 16'(w_step);
                    end
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= F_IDLE;
            r_char_index  <= 16'd0;
            r_line_length <= 16'd0;
            r_line_top    <= 16'd0;
        end else begin
            r_state       <= n_state;
            r_char_index  <= n_char_index;
            r_line_length <= n_line_length;
            r_line_top    <= n_line_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
        end
        if (r_state == F_MUL) begin
            r_prod <= 16'(r_char_index * 16'(w_step));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_color  <= 8'd0;
            r_origin_x    <= 8'd0;
            r_origin_y    <= 8'd0;
            r_scale       <= SCALE_MIN;
            r_wrap_enable <= 1'b0;
            r_line_limit  <= LIMIT_INIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DRAW_COLOR:  r_draw_color  <= i_cfg_data[7:0];
                CFG_ORIGIN_X:    r_origin_x    <= i_cfg_data[7:0];
                CFG_ORIGIN_Y:    r_origin_y    <= i_cfg_data[7:0];
                CFG_SCALE:       r_scale       <= i_cfg_data[3:0];
                CFG_WRAP_ENABLE: r_wrap_enable <= i_cfg_data[0];
                CFG_LINE_LIMIT:  r_line_limit  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/sgtr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module sgtr_queue import sgtr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_job i_push_job,
    output logic      o_pop_valid,
    input  wire logic i_pop_ready,
    output t_job      o_pop_job
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_job    = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

endmodule
`default_nettype wire

// ===== src/sgtr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Renderer back end
// Owns the glyph store, writes loaded rows and scans printed glyphs into squares.
// ----------------------------------------------------------------------------
module sgtr_back import sgtr_pkg::*; #(
    parameter int CHAR_COUNT   = 256,
    parameter int GLYPH_HEIGHT = 12,
    parameter int GLYPH_WIDTH  = 5
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    output logic      o_job_ready,
    input  wire t_job i_job,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    localparam int DEPTH  = CHAR_COUNT * GLYPH_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_SCAN  = 2'd1;
    localparam logic [1:0] B_FLUSH = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [ADDR_W-1:0]      r_addr;
    logic [ROW_IDX_W-1:0]   r_row;
    logic [15:0]            r_y;
    logic [15:0]            r_left;
    logic [3:0]             r_side;
    logic [7:0]             r_color;
    logic [MAX_GLYPH_W-1:0] r_bits;
    logic                   r_use_rd, n_use_rd;
    logic                   r_p_valid, n_p_valid;
    logic [15:0]            r_p_x, r_p_y;
    logic                   r_out_valid, n_out_valid;
    t_out                   r_out;

    logic                   w_we, w_re;
    logic [ADDR_W-1:0]      w_raddr;
    logic [GLYPH_WIDTH-1:0] w_rdata;
    logic [MAX_GLYPH_W-1:0] w_cur, w_rem;
    logic [COL_IDX_W-1:0]   w_col;
    logic                   w_found;
    logic                   w_out_free;
    logic                   w_go;
    logic                   w_load_out;
    t_out                   w_out;
    logic                   w_start;

    sgtr_ram #(
        .WIDTH (GLYPH_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_job.addr[ADDR_W-1:0]),
        .i_wdata (i_job.bits[GLYPH_WIDTH-1:0]),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_job_ready = (r_state == B_IDLE);
    assign w_we    = i_job_valid && o_job_ready && !i_job.is_print && i_job.ok;
    assign w_start = i_job_valid && o_job_ready && i_job.is_print && i_job.ok;
    assign w_cur   = r_use_rd ? MAX_GLYPH_W'(w_rdata) : r_bits;
    assign w_found = (w_cur != '0);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_go    = !(w_found && r_p_valid && !w_out_free);

    always_comb begin
        w_col = '0;
        for (int k = MAX_GLYPH_W - 1; k >= 0; k--) begin
            if (w_cur[k]) begin
                w_col = COL_IDX_W'(k);
            end
        end
        w_rem = w_found ? (w_cur & ~(MAX_GLYPH_W'(1) << w_col)) : '0;
    end

    always_comb begin
        n_state     = r_state;
        n_use_rd    = r_use_rd;
        n_p_valid   = r_p_valid;
        w_re        = 1'b0;
        w_raddr     = r_addr + ADDR_W'(1);
        w_load_out  = 1'b0;
        w_out.rect_x = r_p_x;
        w_out.rect_y = r_p_y;
        w_out.side   = r_side;
        w_out.color  = r_color;
        w_out.last   = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (w_start) begin
                    w_re     = 1'b1;
                    w_raddr  = i_job.addr[ADDR_W-1:0];
                    n_use_rd = 1'b1;
                    n_state  = B_SCAN;
                end
            end
            B_SCAN: begin
                if (w_go) begin
                    if (w_found) begin
                        n_p_valid  = 1'b1;
                        w_load_out = r_p_valid;
                    end
                    if (w_rem == '0) begin
                        if (r_row == ROW_IDX_W'(GLYPH_HEIGHT - 1)) begin
                            n_state = B_FLUSH;
                        end else begin
                            w_re     = 1'b1;
                            n_use_rd = 1'b1;
                        end
                    end else begin
                        n_use_rd = 1'b0;
                    end
                end
            end
            B_FLUSH: begin
                if (!r_p_valid) begin
                    n_state = B_IDLE;
                end else if (w_out_free) begin
                    w_load_out  = 1'b1;
                    w_out.last  = 1'b1;
                    n_p_valid   = 1'b0;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || w_load_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_use_rd    <= 1'b0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_use_rd    <= n_use_rd;
            r_p_valid   <= n_p_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_addr  <= i_job.addr[ADDR_W-1:0];
            r_row   <= '0;
            r_y     <= i_job.top;
            r_left  <= i_job.left;
            r_side  <= i_job.side;
            r_color <= i_job.color;
        end else if (r_state == B_SCAN && w_go) begin
            r_bits <= w_rem;
            if (w_found) begin
                r_p_x <= r_left + 16'(w_col) * 16'(r_side);
                r_p_y <= r_y;
            end
            if (w_rem == '0 && r_row != ROW_IDX_W'(GLYPH_HEIGHT - 1)) begin
                r_addr <= r_addr + ADDR_W'(1);
                r_row  <= r_row + ROW_IDX_W'(1);
                r_y    <= r_y + 16'(r_side);
            end
        end
        if (w_load_out) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== src/scaled_glyph_text_renderer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled glyph text renderer
// Character generator that draws scaled bitmap glyphs as filled squares.
// ----------------------------------------------------------------------------
// The input channel takes load items, which write one glyph row into the
// glyph store, and print items, which draw one character at the text cursor.
// Each print item yields one square item on the output channel for every lit
// glyph cell, scanned from the top row and from column 0, and the final
// square of a character carries last. A blank glyph yields no item.
// The configuration channel writes the six registers and is always ready.
// The front end takes a print item through its wrap, multiply and push states and
// a load item straight to push. The back end writes a load into the glyph store;
// on a print it scans every row, also rows without a lit cell, and then flushes
// the final square. It reads the glyph store one row at a time.
// A two-entry job queue lets the front end take new items while squares of
// an earlier character are still being drawn.
// When the receiver stalls, the output register holds its item, the back end
// waits, and once the queue is full the input channel drops ready.
// Reset clears the cursor, the queue and the output register and restores the
// register defaults. The glyph store is not cleared and must be loaded first.
// ----------------------------------------------------------------------------
module scaled_glyph_text_renderer_unit import sgtr_pkg::*; #(
    parameter int CHAR_COUNT   = 256,
    parameter int GLYPH_HEIGHT = 12,
    parameter int GLYPH_WIDTH  = 5,
    parameter int SCREEN_WIDTH = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic w_push_valid, w_push_ready;
    t_job w_push_job;
    logic w_pop_valid, w_pop_ready;
    t_job w_pop_job;

    sgtr_front #(
        .CHAR_COUNT   (CHAR_COUNT),
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_job_valid (w_push_valid),
        .i_job_ready (w_push_ready),
        .o_job       (w_push_job)
    );

    sgtr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_job    (w_pop_job)
    );

    sgtr_back #(
        .CHAR_COUNT   (CHAR_COUNT),
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .GLYPH_WIDTH  (GLYPH_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_pop_valid),
        .o_job_ready (w_pop_ready),
        .i_job       (w_pop_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== tb/sv/scaled_glyph_text_renderer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Scaled glyph text renderer testbench
// Loads glyphs, prints characters under several register settings and checks every
// emitted square against a cycle-free model of the character generator or probes.
// ----------------------------------------------------------------------------
module scaled_glyph_text_renderer_unit_tb;
    import sgtr_pkg::*;

    localparam int FONT_CODES    = 256;
    localparam int GLYPH_H       = 12;
    localparam int GLYPH_W       = 5;
    localparam int SCREEN_W      = 256;
    localparam int RANDOM_ITEMS  = 384;
    localparam int PHASES        = 8;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct {
        t_in  item;
        bit   typed;
        bit   has_square;
        t_out square;
    } t_probe;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in                   in_data   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_ready;
    logic                  out_valid;
    t_out                  out_data;
    logic                  cfg_ready;

    logic [7:0]  cfg_color    = 8'd0;
    logic [7:0]  cfg_origin_x = 8'd0;
    logic [7:0]  cfg_origin_y = 8'd0;
    logic [3:0]  cfg_scale    = SCALE_MIN;
    logic        cfg_wrap     = 1'b0;
    logic [15:0] cfg_limit    = LIMIT_INIT;

    logic [4:0]         font [FONT_CODES*GLYPH_H];
    bit [GLYPH_H-1:0]   rows_seen [FONT_CODES];
    bit                 glyph_ready [FONT_CODES];
    logic [7:0]         ready_codes [$];
    logic [15:0]        col_index  = 16'd0;
    logic [15:0]        line_pos   = 16'd0;
    logic [15:0]        line_top_y = 16'd0;

    t_out squares_due [$];
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    bit   steady         = 1'b0;
    bit   hold_request   = 1'b0;

    scaled_glyph_text_renderer_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic t_in load_op(input logic [7:0] code, input logic [3:0] row,
                                    input logic [4:0] bits);
        t_in it;
        it.action        = ACT_LOAD;
        it.first_of_text = 1'b0;
        it.char_code     = code;
        it.glyph_row     = row;
        it.row_bits      = bits;
        return it;
    endfunction

    function automatic t_in print_op(input logic first, input logic [7:0] code);
        t_in it;
        it.action        = ACT_PRINT;
        it.first_of_text = first;
        it.char_code     = code;
        it.glyph_row     = 4'($urandom());
        it.row_bits      = 5'($urandom());
        return it;
    endfunction

    function automatic t_out square_at(input logic [15:0] x, input logic [15:0] y);
        t_out sq;
        sq.rect_x = x;
        sq.rect_y = y;
        sq.side   = SCALE_MIN;
        sq.color  = 8'd0;
        sq.last   = 1'b1;
        return sq;
    endfunction

    task automatic predict_squares(input t_in it, input bit keep);
        int   sc;
        int   stride;
        int   lead;
        t_out sq;
        t_out cells [$];
        if (it.action == ACT_LOAD) begin
            if (it.glyph_row < GLYPH_H) begin
                font[int'(it.char_code)*GLYPH_H + int'(it.glyph_row)] = it.row_bits;
                rows_seen[it.char_code][it.glyph_row] = 1'b1;
                if (&rows_seen[it.char_code] && !glyph_ready[it.char_code]) begin
                    glyph_ready[it.char_code] = 1'b1;
                    ready_codes.push_back(it.char_code);
                end
            end
            return;
        end
        if (cfg_scale == 4'd0) begin
            sc = int'(SCALE_MIN);
        end else if (cfg_scale > SCALE_MAX) begin
            sc = int'(SCALE_MAX);
        end else begin
            sc = int'(cfg_scale);
        end
        stride = (GLYPH_W + 1) * sc;
        if (it.first_of_text) begin
            col_index  = 16'd0;
            line_pos   = 16'(cfg_origin_x);
            line_top_y = 16'(cfg_origin_y);
        end
        if (cfg_wrap && (int'(line_pos) + stride > int'(cfg_limit) ||
                         int'(line_pos) + stride > SCREEN_W)) begin
            line_top_y = line_top_y + 16'(GLYPH_H * sc);
            col_index  = 16'd0;
            line_pos   = 16'(cfg_origin_x);
        end
        lead = int'(cfg_origin_x) + int'(col_index) * stride;
        for (int r = 0; r < GLYPH_H; r++) begin
            for (int c = 0; c < GLYPH_W; c++) begin
                if (font[int'(it.char_code)*GLYPH_H + r][c]) begin
                    sq.rect_x = 16'(lead + c * sc);
                    sq.rect_y = 16'(int'(line_top_y) + r * sc);
                    sq.side   = 4'(sc);
                    sq.color  = cfg_color;
                    sq.last   = 1'b0;
                    cells.push_back(sq);
                end
            end
        end
        if (cells.size() > 0) begin
            cells[cells.size()-1].last = 1'b1;
        end
        if (keep) begin
            foreach (cells[k]) begin
                squares_due.push_back(cells[k]);
            end
        end
        col_index = col_index + 16'd1;
        line_pos  = line_pos + 16'(stride);
    endtask

    task automatic push_item(input t_in it, input bit keep);
        while (!steady && $urandom_range(99) < 18) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        predict_squares(it, keep);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (squares_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            CFG_DRAW_COLOR:  cfg_color    = data[7:0];
            CFG_ORIGIN_X:    cfg_origin_x = data[7:0];
            CFG_ORIGIN_Y:    cfg_origin_y = data[7:0];
            CFG_SCALE:       cfg_scale    = data[3:0];
            CFG_WRAP_ENABLE: cfg_wrap     = data[0];
            CFG_LINE_LIMIT:  cfg_limit    = data[15:0];
            default: ;
        endcase
    endtask

    task automatic configure_phase(input int phase);
        logic [7:0]  color;
        logic [7:0]  ox;
        logic [7:0]  oy;
        logic [3:0]  scl;
        logic        wrp;
        logic [15:0] lim;
        color = 8'($urandom());
        ox    = 8'($urandom());
        oy    = 8'($urandom());
        scl   = 4'($urandom_range(15));
        wrp   = 1'($urandom());
        lim   = ($urandom_range(1) == 1) ? 16'($urandom()) : 16'($urandom_range(300));
        case (phase)
            0: begin
                color = 8'hFF;
                ox    = 8'hFF;
                oy    = 8'hFF;
                scl   = SCALE_MAX;
                wrp   = 1'b1;
                lim   = 16'hFFFF;
            end
            1: begin
                color = 8'h00;
                ox    = 8'h00;
                oy    = 8'h00;
                scl   = SCALE_MIN;
                wrp   = 1'b0;
                lim   = 16'h0000;
            end
            2: begin
                scl = 4'd0;
                wrp = 1'b1;
                lim = 16'h0000;
            end
            3: begin
                scl = 4'd15;
                wrp = 1'b1;
            end
            4: begin
                scl = 4'd9;
                wrp = 1'b0;
            end
            default: ;
        endcase
        write_reg(CFG_DRAW_COLOR, {8'($urandom()), color});
        write_reg(CFG_ORIGIN_X, {8'($urandom()), ox});
        write_reg(CFG_ORIGIN_Y, {8'($urandom()), oy});
        write_reg(CFG_SCALE, {12'($urandom()), scl});
        write_reg(CFG_WRAP_ENABLE, {15'($urandom()), wrp});
        write_reg(CFG_LINE_LIMIT, lim);
        write_reg(CFG_SPARE_A, 16'($urandom()));
        write_reg(CFG_SPARE_B, 16'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    initial begin : square_sink
        t_out got;
        t_out want;
        int   hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                got = out_data;
                if (squares_due.size() == 0) begin
                    report_mismatch($sformatf("square at (%0d,%0d) with nothing pending",
                                              got.rect_x, got.rect_y));
                end else begin
                    want = squares_due.pop_front();
                    if (got.rect_x !== want.rect_x)
                        report_mismatch($sformatf("rect_x got %0d expected %0d",
                                                  got.rect_x, want.rect_x));
                    if (got.rect_y !== want.rect_y)
                        report_mismatch($sformatf("rect_y got %0d expected %0d",
                                                  got.rect_y, want.rect_y));
                    if (got.side !== want.side)
                        report_mismatch($sformatf("side got %0d expected %0d",
                                                  got.side, want.side));
                    if (got.color !== want.color)
                        report_mismatch($sformatf("color got %0d expected %0d",
                                                  got.color, want.color));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last got %0d expected %0d",
                                                  got.last, want.last));
                end
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (steady) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= 18);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("scaled_glyph_text_renderer_unit test failed");
        $finish;
    end

    initial begin : stimulus
        t_probe     probes [$];
        t_probe     p;
        int         sent;
        int         r;
        int         start;
        bit         dense;
        logic [7:0] code;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Glyph 0 has a single cell at the top left, glyph 255 has every cell lit.
        for (int row = 0; row < GLYPH_H; row++) begin
            push_item(load_op(8'd0, 4'(row), (row == 0) ? 5'b00001 : 5'b00000), 1'b1);
            push_item(load_op(8'd255, 4'(row), 5'h1F), 1'b1);
        end

        p = '{item: print_op(1'b1, 8'd0), typed: 1'b1, has_square: 1'b1,
              square: square_at(16'd0, 16'd0)};
        probes.push_back(p);
        p = '{item: print_op(1'b0, 8'd0), typed: 1'b1, has_square: 1'b1,
              square: square_at(16'd6, 16'd0)};
        probes.push_back(p);
        p = '{item: load_op(8'd0, 4'd15, 5'h1F), typed: 1'b1, has_square: 1'b0,
              square: '0};
        probes.push_back(p);
        p = '{item: load_op(8'd0, 4'd12, 5'h1F), typed: 1'b1, has_square: 1'b0,
              square: '0};
        probes.push_back(p);
        p = '{item: print_op(1'b0, 8'd0), typed: 1'b1, has_square: 1'b1,
              square: square_at(16'd12, 16'd0)};
        probes.push_back(p);
        p = '{item: load_op(8'd0, 4'd0, 5'h00), typed: 1'b1, has_square: 1'b0,
              square: '0};
        probes.push_back(p);
        p = '{item: print_op(1'b0, 8'd0), typed: 1'b1, has_square: 1'b0, square: '0};
        probes.push_back(p);
        p = '{item: load_op(8'd0, 4'd11, 5'b10000), typed: 1'b1, has_square: 1'b0,
              square: '0};
        probes.push_back(p);
        p = '{item: print_op(1'b1, 8'd0), typed: 1'b1, has_square: 1'b1,
              square: square_at(16'd4, 16'd11)};
        probes.push_back(p);
        p = '{item: print_op(1'b0, 8'd255), typed: 1'b0, has_square: 1'b0, square: '0};
        probes.push_back(p);
        p = '{item: load_op(8'd255, 4'd5, 5'h00), typed: 1'b0, has_square: 1'b0,
              square: '0};
        probes.push_back(p);
        p = '{item: print_op(1'b0, 8'd255), typed: 1'b0, has_square: 1'b0, square: '0};
        probes.push_back(p);
        p = '{item: print_op(1'b1, 8'd255), typed: 1'b0, has_square: 1'b0, square: '0};
        probes.push_back(p);

        foreach (probes[k]) begin
            push_item(probes[k].item, !probes[k].typed);
            if (probes[k].typed && probes[k].has_square) begin
                squares_due.push_back(probes[k].square);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            configure_phase(phase);
            steady = (phase == 4);
            if (phase == 2 || phase == 6) begin
                hold_request = 1'b1;
            end
            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES) begin
                r = $urandom_range(99);
                if (ready_codes.size() < 4 || r < 7) begin
                    code  = 8'($urandom());
                    start = $urandom_range(GLYPH_H - 1);
                    dense = ($urandom_range(5) == 0);
                    for (int n = 0; n < GLYPH_H; n++) begin
                        push_item(load_op(code, 4'((start + n) % GLYPH_H),
                                          dense ? 5'h1F : 5'($urandom())), 1'b1);
                    end
                    sent += GLYPH_H;
                end else if (r < 11) begin
                    push_item(load_op(8'($urandom()), 4'($urandom_range(15, GLYPH_H)),
                                      5'($urandom())), 1'b1);
                    sent++;
                end else if (r < 17) begin
                    code = ready_codes[$urandom_range(ready_codes.size() - 1)];
                    push_item(load_op(code, 4'($urandom_range(GLYPH_H - 1)),
                                      5'($urandom())), 1'b1);
                    sent++;
                end else begin
                    code = ready_codes[$urandom_range(ready_codes.size() - 1)];
                    push_item(print_op($urandom_range(99) < 12, code), 1'b1);
                    sent++;
                end
            end
        end
        steady = 1'b0;
        drain();

        if (mismatch_count == 0) begin
            $display("scaled_glyph_text_renderer_unit test passed");
        end else begin
            $display("scaled_glyph_text_renderer_unit test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/sgtr_pkg.sv
src/sgtr_ram.sv
src/sgtr_front.sv
src/sgtr_queue.sv
src/sgtr_back.sv
src/scaled_glyph_text_renderer_unit.sv
tb/sv/scaled_glyph_text_renderer_unit_tb.sv
